// ===== hw/rtl/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_TIMES = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_NL    = 8'h0A;

   typedef enum logic [2:0] {
      OP_PLUS  = 3'd0,
      OP_MINUS = 3'd1,
      OP_TIMES = 3'd2,
      OP_DIV   = 3'd3,
      OP_CARET = 3'd4,
      OP_OPEN  = 3'd5,
      OP_CLOSE = 3'd6,
      OP_NONE  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNMATCHED = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ACT_IDLE      = 3'd0,
      ACT_POP       = 3'd1,
      ACT_DROP      = 3'd2,
      ACT_PUSH      = 3'd3,
      ACT_PASS      = 3'd4,
      ACT_OVERFLOW  = 3'd5,
      ACT_UNMATCHED = 3'd6,
      ACT_NEWLINE   = 3'd7
   } act_type;

   typedef struct packed {
      logic    load;
      act_type act;
      logic    finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic   is_end;
      op_type cls;
      logic   empty;
      logic   full;
      op_type top;
      logic   can_emit;
   } dp_status_type;

   function automatic op_type classify(input logic [7:0] ch);
      op_type r;
      case (ch)
         CHAR_PLUS:  r = OP_PLUS;
         CHAR_MINUS: r = OP_MINUS;
         CHAR_TIMES: r = OP_TIMES;
         CHAR_DIV:   r = OP_DIV;
         CHAR_CARET: r = OP_CARET;
         CHAR_OPEN:  r = OP_OPEN;
         CHAR_CLOSE: r = OP_CLOSE;
         default:    r = OP_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_char(input op_type op);
      logic [7:0] r;
      case (op)
         OP_PLUS:  r = CHAR_PLUS;
         OP_MINUS: r = CHAR_MINUS;
         OP_TIMES: r = CHAR_TIMES;
         OP_DIV:   r = CHAR_DIV;
         OP_CARET: r = CHAR_CARET;
         OP_OPEN:  r = CHAR_OPEN;
         default:  r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] op_prec(input op_type op);
      logic [1:0] r;
      case (op)
         OP_PLUS, OP_MINUS: r = 2'd1;
         OP_TIMES, OP_DIV:  r = 2'd2;
         OP_CARET:          r = 2'd3;
         default:           r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/itp_ctrl.sv =====
`timescale 1ns / 1ps

module itp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  itp_pkg::dp_status_type status,
   output itp_pkg::ctrl_cmd_type  cmd
);
   import itp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   act_type   want;
   logic      emits;
   logic      terminal;

   // next step of the current character
   always_comb begin
      want = ACT_PASS;
      if (status.is_end) begin
         want = status.empty ? ACT_NEWLINE : ACT_POP;
      end else begin
         case (status.cls)
            OP_PLUS, OP_MINUS, OP_TIMES, OP_DIV, OP_CARET: begin
               if (!status.empty && status.top != OP_OPEN && status.cls != OP_CARET &&
                   op_prec(status.top) >= op_prec(status.cls)) begin
                  want = ACT_POP;
               end else begin
                  want = status.full ? ACT_OVERFLOW : ACT_PUSH;
               end
            end
            OP_OPEN: begin
               want = status.full ? ACT_OVERFLOW : ACT_PUSH;
            end
            OP_CLOSE: begin
               if (status.empty) begin
                  want = ACT_UNMATCHED;
               end else begin
                  want = (status.top == OP_OPEN) ? ACT_DROP : ACT_POP;
               end
            end
            default: begin
               want = ACT_PASS;
            end
         endcase
      end
   end

   always_comb begin
      emits    = (want != ACT_PUSH) && (want != ACT_DROP);
      terminal = (want != ACT_POP);
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.load   = req_tvalid && req_tready;
      cmd.act    = ACT_IDLE;
      cmd.finish = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (!emits || status.can_emit) begin
               cmd.act    = want;
               cmd.finish = terminal;
               if (terminal) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/itp_dpath.sv =====
`timescale 1ns / 1ps

module itp_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  itp_pkg::ctrl_cmd_type  cmd,
   output itp_pkg::dp_status_type status,
   input  logic [7:0]            in_symbol,
   input  logic                  in_end,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_symbol,
   output logic                  out_line_end,
   output logic [1:0]            out_error,
   output logic                  out_last
);
   import itp_pkg::*;

   logic [7:0]       sym_ff;
   logic             end_ff;
   logic [2:0]       stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_dec;
   logic [PTR_W-1:0] top_idx;
   logic [PTR_W-1:0] push_idx;
   op_type           sym_cls;
   op_type           top_op;

   logic             hold_valid_ff, hold_valid_in;
   logic             hold_done_ff, hold_done_in;
   logic [7:0]       hold_sym_ff;
   logic             hold_le_ff;
   err_type          hold_err_ff;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_sym_ff;
   logic             out_le_ff;
   err_type          out_err_ff;
   logic             out_last_ff;

   logic             emit;
   logic [7:0]       emit_sym;
   logic             emit_le;
   err_type          emit_err;
   logic             out_free;
   logic             shift;

   always_comb begin
      sym_cls   = classify(sym_ff);
      count_dec = count_ff - CNT_W'(1);
      top_idx   = count_dec[PTR_W-1:0];
      push_idx  = count_ff[PTR_W-1:0];
      top_op    = op_type'(stack_ff[top_idx]);
   end

   always_comb begin
      emit     = 1'b1;
      emit_sym = sym_ff;
      emit_le  = 1'b0;
      emit_err = ERR_NONE;
      count_in = count_ff;
      case (cmd.act)
         ACT_POP: begin
            emit_sym = op_char(top_op);
            count_in = count_dec;
         end
         ACT_DROP: begin
            emit     = 1'b0;
            count_in = count_dec;
         end
         ACT_PUSH: begin
            emit     = 1'b0;
            count_in = count_ff + CNT_W'(1);
         end
         ACT_PASS: begin
            emit_sym = sym_ff;
         end
         ACT_OVERFLOW: begin
            emit_err = ERR_OVERFLOW;
            count_in = '0;
         end
         ACT_UNMATCHED: begin
            emit_err = ERR_UNMATCHED;
         end
         ACT_NEWLINE: begin
            emit_sym = CHAR_NL;
            emit_le  = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // hold stage keeps the newest result until its last flag is known
   always_comb begin
      out_free = !out_valid_ff || out_ready;
      shift    = hold_valid_ff && (hold_done_ff || emit) && out_free;

      hold_valid_in = hold_valid_ff;
      hold_done_in  = hold_done_ff;
      if (emit) begin
         hold_valid_in = 1'b1;
         hold_done_in  = cmd.finish;
      end else begin
         if (shift) begin
            hold_valid_in = 1'b0;
         end
         if (cmd.finish) begin
            hold_done_in = 1'b1;
         end
      end

      out_valid_in = out_valid_ff;
      if (shift) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      status.is_end   = end_ff;
      status.cls      = sym_cls;
      status.empty    = (count_ff == '0);
      status.full     = (count_ff >= CNT_W'(STACK_DEPTH));
      status.top      = top_op;
      status.can_emit = !hold_valid_ff || out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         hold_done_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         hold_done_ff  <= hold_done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sym_ff <= in_symbol;
         end_ff <= in_end;
      end
      if (cmd.act == ACT_PUSH) begin
         stack_ff[push_idx] <= sym_cls;
      end
      if (emit) begin
         hold_sym_ff <= emit_sym;
         hold_le_ff  <= emit_le;
         hold_err_ff <= emit_err;
      end
      if (shift) begin
         out_sym_ff  <= hold_sym_ff;
         out_le_ff   <= hold_le_ff;
         out_err_ff  <= hold_err_ff;
         out_last_ff <= hold_done_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_symbol   = out_sym_ff;
   assign out_line_end = out_le_ff;
   assign out_error    = out_err_ff;
   assign out_last     = out_last_ff;

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata               tuser                      tlast
// req_     in   [7:0] symbol        -                          end of expression
// rsp_     out  [7:0] out_symbol    [0] line_end, [2:1] error  last result of a character
//
// One character is taken, then worked one stack step per cycle while the rsp_ side
// does not stall: an operand, push or '(' takes one step, plus one step per operator popped.
// The operator stack register file and the single hold/output pair set this.
// Reset (synchronous) empties the stack; stack contents are not cleared.
// A stalled rsp_ side stops the work loop at its next result; req_tready
// stays low until the current character is finished.

module infix_to_postfix_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_symbol
   output logic [2:0]  rsp_tuser,   // [0] line_end, [2:1] error_code
   output logic        rsp_tlast
);
   import itp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          line_end;
   logic [1:0]    error_code;

   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   itp_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_symbol    (req_tdata),
      .in_end       (req_tlast),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_symbol   (rsp_tdata),
      .out_line_end (line_end),
      .out_error    (error_code),
      .out_last     (rsp_tlast)
   );

   assign rsp_tuser = {error_code, line_end};

endmodule

// ===== verif/tb_infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;
   import itp_pkg::*;

   typedef struct {
      logic [7:0] sym;
      logic       line_end;
      err_type    err;
      logic       last;
   } postfix_out_type;

   function automatic op_type char_to_op(input logic [7:0] ch);
      if (ch == CHAR_PLUS)  return OP_PLUS;
      if (ch == CHAR_MINUS) return OP_MINUS;
      if (ch == CHAR_TIMES) return OP_TIMES;
      if (ch == CHAR_DIV)   return OP_DIV;
      if (ch == CHAR_CARET) return OP_CARET;
      if (ch == CHAR_OPEN)  return OP_OPEN;
      if (ch == CHAR_CLOSE) return OP_CLOSE;
      return OP_NONE;
   endfunction

   function automatic logic [7:0] op_symbol(input op_type op);
      logic [7:0] lut [6];
      lut = '{CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIV, CHAR_CARET, CHAR_OPEN};
      return (op <= OP_OPEN) ? lut[op] : 8'h00;
   endfunction

   // binding strength; '(' is lowest so it never gets popped by an operator
   function automatic int op_rank(input op_type op);
      if (op == OP_CARET) return 3;
      if (op == OP_TIMES || op == OP_DIV) return 2;
      if (op == OP_PLUS || op == OP_MINUS) return 1;
      return 0;
   endfunction

   class postfix_scoreboard;
      op_type          op_stack [STACK_DEPTH];
      int              op_count;
      postfix_out_type run_out [$];
      postfix_out_type pending_out [$];
      int              mismatches;
      int              checked;
      int              overflows;
      int              unmatched;
      int              lines;

      function new();
         op_count   = 0;
         mismatches = 0;
         checked    = 0;
         overflows  = 0;
         unmatched  = 0;
         lines      = 0;
      endfunction

      function void add_out(input logic [7:0] s, input logic le, input err_type e);
         postfix_out_type o;
         o.sym      = s;
         o.line_end = le;
         o.err      = e;
         o.last     = 1'b0;
         run_out.push_back(o);
      endfunction

      function void pop_top();
         add_out(op_symbol(op_stack[op_count - 1]), 1'b0, ERR_NONE);
         op_count--;
      endfunction

      function void push_op(input op_type op, input logic [7:0] s);
         if (op_count >= STACK_DEPTH) begin
            add_out(s, 1'b0, ERR_OVERFLOW);
            op_count = 0;
            overflows++;
         end else begin
            op_stack[op_count] = op;
            op_count++;
         end
      endfunction

      // predicts the results released by one accepted transfer
      function void note_char(input logic [7:0] s, input logic end_mark);
         op_type cls;
         op_type top;
         bit     found;
         run_out.delete();
         cls = char_to_op(s);
         if (end_mark) begin
            while (op_count != 0) pop_top();
            add_out(CHAR_NL, 1'b1, ERR_NONE);
            lines++;
         end else if (cls == OP_NONE) begin
            add_out(s, 1'b0, ERR_NONE);
         end else if (cls == OP_OPEN) begin
            push_op(OP_OPEN, s);
         end else if (cls == OP_CLOSE) begin
            found = 1'b0;
            while (op_count != 0) begin
               if (op_stack[op_count - 1] == OP_OPEN) begin
                  op_count--;
                  found = 1'b1;
                  break;
               end
               pop_top();
            end
            if (!found) begin
               add_out(s, 1'b0, ERR_UNMATCHED);
               unmatched++;
            end
         end else begin
            while (op_count != 0) begin
               top = op_stack[op_count - 1];
               if (top == OP_OPEN || cls == OP_CARET || op_rank(top) < op_rank(cls)) break;
               pop_top();
            end
            push_op(cls, s);
         end
         if (run_out.size() > 0) run_out[run_out.size() - 1].last = 1'b1;
         foreach (run_out[i]) pending_out.push_back(run_out[i]);
      endfunction

      function void check_output(input logic [7:0] d, input logic [2:0] u, input logic l);
         postfix_out_type e;
         checked++;
         if (pending_out.size() == 0) begin
            $error("unexpected result: out_symbol %0h", d);
            mismatches++;
            return;
         end
         e = pending_out.pop_front();
         if (d !== e.sym) begin
            $error("out_symbol: expected %0h, actual %0h", e.sym, d);
            mismatches++;
         end
         if (u[0] !== e.line_end) begin
            $error("line_end: expected %0b, actual %0b", e.line_end, u[0]);
            mismatches++;
         end
         if (u[2:1] !== e.err) begin
            $error("error_code: expected %0d, actual %0d", e.err, u[2:1]);
            mismatches++;
         end
         if (l !== e.last) begin
            $error("last_of_run: expected %0b, actual %0b", e.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   postfix_scoreboard sb = new();

   int send_idle   = 0;
   int recv_idle   = 0;
   int items_sent  = 0;
   bit hold_req    = 1'b0;
   int hold_left   = 0;
   int hold_stalls = 0;

   logic [7:0] op_chars [5] = '{CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIV, CHAR_CARET};

   infix_to_postfix_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_infix_to_postfix_converter failed");
      $finish;
   end

   // result side: check transfers, random backpressure, long hold on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         if (req_tvalid && !req_tready) hold_stalls++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_char(input logic [7:0] sym, input logic end_mark = 1'b0);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= end_mark;
      do @(posedge clock); while (!req_tready);
      sb.note_char(sym, end_mark);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_out.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_operand();
      logic [7:0] s;
      do begin
         s = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(97, 122));
      end while (char_to_op(s) != OP_NONE);
      return s;
   endfunction

   // balanced expression; optionally one stray ')' near the end
   task automatic send_expression(input bit stray_close);
      int terms;
      int opens;
      terms = $urandom_range(1, 6);
      opens = 0;
      for (int i = 0; i < terms; i++) begin
         if ($urandom_range(3) == 0 && opens < 5) begin
            send_char(CHAR_OPEN);
            opens++;
         end
         send_char(pick_operand());
         if (opens > 0 && $urandom_range(2) == 0) begin
            send_char(CHAR_CLOSE);
            opens--;
         end
         if (i < terms - 1) send_char(op_chars[$urandom_range(4)]);
      end
      while (opens > 0) begin
         send_char(CHAR_CLOSE);
         opens--;
      end
      if (stray_close) begin
         send_char(op_chars[$urandom_range(4)]);
         send_char(pick_operand());
         send_char(CHAR_CLOSE);
      end
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   // pushes that never pop, around the stack limit
   task automatic send_deep();
      int n;
      n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(5) == 0) send_char(pick_operand());
         send_char($urandom_range(1) ? CHAR_OPEN : CHAR_CARET);
      end
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(2))
            0: send_char(8'($urandom_range(255)));
            1: send_char(op_chars[$urandom_range(4)]);
            default: send_char($urandom_range(1) ? CHAR_OPEN : CHAR_CLOSE);
         endcase
      end
      if ($urandom_range(1)) send_char(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_random_sequence();
      int r;
      r = $urandom_range(99);
      if (r < 60)      send_expression(1'b0);
      else if (r < 68) send_deep();
      else if (r < 80) send_expression(1'b1);
      else             send_noise();
   endtask

   initial begin
      int goal;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // precedence, associativity, parentheses
      send_text("(a-b)*c^d^e/f+g");
      send_char(8'h00, 1'b1);
      // close with empty stack
      send_text("a)");
      // odd operand bytes, then leftover opens flushed at end
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_NL);
      send_text("((");
      send_char(8'hFF, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 31 : (phase == 1) ? 62 : 0;
         recv_idle = (phase == 0) ? 62 : (phase == 1) ? 31 : 0;
         if (phase == 2) begin
            hold_req = 1'b1;
            send_deep();
            send_expression(1'b0);
         end
         goal = items_sent + 28;
         while (items_sent < goal) send_random_sequence();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d characters, %0d results, %0d lines, %0d overflows, %0d unmatched",
               items_sent, sb.checked, sb.lines, sb.overflows, sb.unmatched);
      $display("input stalled %0d cycles during the long output hold", hold_stalls);
      if (sb.mismatches == 0 && sb.pending_out.size() == 0) begin
         $display("tb_infix_to_postfix_converter passed");
      end else begin
         $display("tb_infix_to_postfix_converter failed");
      end
      $finish;
   end

endmodule
